// ===== sv/tkqs_pkg.sv =====
package tkqs_pkg;

    // store geometry
    localparam int MAX_KEEP = 16;
    localparam int SLOT_W   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
    localparam int CNT_W    = $clog2(MAX_KEEP + 1);

    // field widths
    localparam int POS_W   = 32;
    localparam int QUAL_W  = 16;
    localparam int AGE_W   = 16;
    localparam int KEEP_W  = 5;
    localparam int TOL_W   = 15;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = TOL_W;

    localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_TOLERANCE = 1'b1;

    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;
    localparam logic [TOL_W-1:0]  TOL_RESET  = 15'd492;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic [POS_W-1:0]         loop_start;
        logic [POS_W-1:0]         loop_end;
        logic signed [QUAL_W-1:0] quality;
        logic                     set_last;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]         kept_start;
        logic [POS_W-1:0]         kept_end;
        logic signed [QUAL_W-1:0] kept_quality;
        logic                     final_result;
    } t_out_item;

    // entry summary that circulates around the ring of cells
    typedef struct packed {
        logic                     valid;
        logic signed [QUAL_W-1:0] quality;
        logic [POS_W-1:0]         len;
        logic [AGE_W-1:0]         age;
        t_slot                    slot;
    } t_ring;

    typedef enum logic [1:0] {
        MODE_MIN   = 2'd0,
        MODE_WORST = 2'd1,
        MODE_RANK  = 2'd2
    } t_scan_mode;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic       load;
        logic       shift;
        t_scan_mode mode;
        logic       put;
        logic       append;
        logic       aging;
        t_cnt       count;
        t_slot      pick_rank;
    } t_cell_cmd;

endpackage

// ===== sv/tkqs_cell.sv =====
module tkqs_cell (
    input  logic                                   i_clk,
    input  tkqs_pkg::t_cell_cmd                    i_cmd,
    input  logic [tkqs_pkg::POS_W-1:0]             i_start,
    input  logic [tkqs_pkg::POS_W-1:0]             i_end,
    input  logic signed [tkqs_pkg::QUAL_W-1:0]     i_quality,
    input  logic [tkqs_pkg::TOL_W-1:0]             i_tol,
    input  tkqs_pkg::t_slot                        i_slot,
    input  tkqs_pkg::t_ring                        i_ring,
    output tkqs_pkg::t_ring                        o_ring,
    output logic                                   o_evict,
    output logic                                   o_pick,
    output tkqs_pkg::t_out_item                    o_entry
);

    // a ranks before b in the output order
    function automatic logic ranks_before(tkqs_pkg::t_ring a, tkqs_pkg::t_ring b);
        logic res;
        if (a.quality != b.quality) begin
            res = $signed(a.quality) > $signed(b.quality);
        end else if (a.len != b.len) begin
            res = a.len > b.len;
        end else if (a.age != b.age) begin
            res = a.age > b.age;
        end else begin
            res = a.slot < b.slot;
        end
        return res;
    endfunction

    // a is a better eviction victim than b: shorter, then older, then lower slot
    function automatic logic evicts_before(tkqs_pkg::t_ring a, tkqs_pkg::t_ring b);
        logic res;
        if (a.len != b.len) begin
            res = a.len < b.len;
        end else if (a.age != b.age) begin
            res = a.age > b.age;
        end else begin
            res = a.slot < b.slot;
        end
        return res;
    endfunction

    // quality lies within the tolerance band above the minimum
    function automatic logic is_near(logic signed [tkqs_pkg::QUAL_W-1:0] q,
                                     logic signed [tkqs_pkg::QUAL_W-1:0] qmin,
                                     logic [tkqs_pkg::TOL_W-1:0]         tol);
        logic signed [tkqs_pkg::QUAL_W:0] d;
        d = $signed({q[tkqs_pkg::QUAL_W-1], q}) - $signed({qmin[tkqs_pkg::QUAL_W-1], qmin});
        return (d == '0) || (d < $signed({2'b00, tol}));
    endfunction

    logic [tkqs_pkg::POS_W-1:0]         r_start;
    logic [tkqs_pkg::POS_W-1:0]         r_end;
    logic [tkqs_pkg::POS_W-1:0]         r_len;
    logic signed [tkqs_pkg::QUAL_W-1:0] r_quality;
    logic [tkqs_pkg::AGE_W-1:0]         r_age;
    tkqs_pkg::t_ring                    r_ring;
    logic signed [tkqs_pkg::QUAL_W-1:0] r_qmin;
    logic                               r_worst;
    tkqs_pkg::t_slot                    r_rank;

    logic            valid;
    logic            we;
    tkqs_pkg::t_ring own;

    // own entry as seen by the ring
    assign valid     = tkqs_pkg::t_cnt'(i_slot) < i_cmd.count;
    assign own.valid   = valid;
    assign own.quality = r_quality;
    assign own.len     = r_len;
    assign own.age     = r_age;
    assign own.slot    = i_slot;

    // write on append into the next free slot, or on eviction of this entry
    assign o_evict = valid && r_worst && (i_quality > r_quality);
    assign we      = i_cmd.put &&
                     (i_cmd.append ? (tkqs_pkg::t_cnt'(i_slot) == i_cmd.count) : o_evict);

    // ring stage and scan accumulators
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ring <= own;
        end else if (i_cmd.shift) begin
            r_ring <= i_ring;
        end

        unique case (i_cmd.mode)
            tkqs_pkg::MODE_MIN: begin
                if (i_cmd.load) begin
                    r_qmin <= r_quality;
                end else if (i_cmd.shift && r_ring.valid &&
                             ($signed(r_ring.quality) < r_qmin)) begin
                    r_qmin <= r_ring.quality;
                end
            end
            tkqs_pkg::MODE_WORST: begin
                if (i_cmd.load) begin
                    r_worst <= valid && is_near(r_quality, r_qmin, i_tol);
                end else if (i_cmd.shift && r_ring.valid &&
                             is_near(r_ring.quality, r_qmin, i_tol) &&
                             evicts_before(r_ring, own)) begin
                    r_worst <= 1'b0;
                end
            end
            tkqs_pkg::MODE_RANK: begin
                if (i_cmd.load) begin
                    r_rank <= '0;
                end else if (i_cmd.shift && r_ring.valid && ranks_before(r_ring, own)) begin
                    r_rank <= r_rank + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // entry storage and aging
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_start   <= i_start;
            r_end     <= i_end;
            r_len     <= i_end - i_start;
            r_quality <= i_quality;
            r_age     <= '0;
        end else if (i_cmd.aging && valid && (r_age != '1)) begin
            r_age <= r_age + 1'b1;
        end
    end

    assign o_ring = r_ring;
    assign o_pick = valid && (r_rank == i_cmd.pick_rank);

    assign o_entry.kept_start   = r_start;
    assign o_entry.kept_end     = r_end;
    assign o_entry.kept_quality = r_quality;
    assign o_entry.final_result = 1'b0;

endmodule

// ===== sv/top_k_quality_selector.sv =====
// channel   | direction | handshake                  | payload
// ----------+-----------+----------------------------+------------------------------
// input     | in        | i_in_valid / o_in_ready    | i_in_item  (t_in_item)
// output    | out       | o_out_valid / i_out_ready  | o_out_item (t_out_item)
// config    | in        | i_cfg_wr_en, no wait       | i_cfg_index, i_cfg_data
//
// an item taken while the store holds fewer than keep_count entries goes straight to the write
// once full, an item first makes a minimum circulation and a victim circulation around the
// ring of MAX_KEEP cells, then the write
// an item with set_last adds a rank circulation, then one result per cycle while the
// output side takes them
// reset is synchronous and clears the entry count and control; no clearing pass runs
// the output register holds a result while the output side stalls; input waits while
// an item is in process and while a set is being emitted
module top_k_quality_selector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  tkqs_pkg::t_in_item                  i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output tkqs_pkg::t_out_item                 o_out_item,
    input  logic                                i_cfg_wr_en,
    input  logic [tkqs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tkqs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_MSCAN = 6'b000010,
        ST_WSCAN = 6'b000100,
        ST_PUT   = 6'b001000,
        ST_RSCAN = 6'b010000,
        ST_EMIT  = 6'b100000
    } t_state;

    // effective keep count: zero acts as one, large values clamp to the store depth
    function automatic tkqs_pkg::t_cnt eff_keep(logic [tkqs_pkg::KEEP_W-1:0] k);
        tkqs_pkg::t_cnt res;
        if (k == '0) begin
            res = tkqs_pkg::t_cnt'(1);
        end else if (32'(k) > tkqs_pkg::MAX_KEEP) begin
            res = tkqs_pkg::t_cnt'(tkqs_pkg::MAX_KEEP);
        end else begin
            res = tkqs_pkg::t_cnt'(k);
        end
        return res;
    endfunction

    t_state                             r_state;
    tkqs_pkg::t_in_item                 r_item;
    logic                               r_append;
    tkqs_pkg::t_cnt                     r_count;
    tkqs_pkg::t_cnt                     r_step;
    tkqs_pkg::t_slot                    r_emit_rank;
    logic [tkqs_pkg::KEEP_W-1:0]        r_keep;
    logic [tkqs_pkg::TOL_W-1:0]         r_tol;
    logic                               r_out_valid;
    tkqs_pkg::t_out_item                r_out;
    tkqs_pkg::t_out_item                n_out;

    tkqs_pkg::t_cell_cmd                cmd;
    tkqs_pkg::t_ring                    ring_in  [tkqs_pkg::MAX_KEEP];
    tkqs_pkg::t_ring                    ring_out [tkqs_pkg::MAX_KEEP];
    tkqs_pkg::t_out_item                entries  [tkqs_pkg::MAX_KEEP];
    logic [tkqs_pkg::MAX_KEEP-1:0]      evict;
    logic [tkqs_pkg::MAX_KEEP-1:0]      pick;
    tkqs_pkg::t_out_item                pick_entry;
    logic                               in_acc;
    logic                               scan_done;
    logic                               emit_go;
    logic                               emit_final;

    assign in_acc     = i_in_valid && o_in_ready;
    assign scan_done  = (r_step == tkqs_pkg::t_cnt'(tkqs_pkg::MAX_KEEP));
    assign emit_go    = (r_state == ST_EMIT) && (!r_out_valid || i_out_ready);
    assign emit_final = (tkqs_pkg::t_cnt'(r_emit_rank) == (r_count - tkqs_pkg::t_cnt'(1)));

    // cell control
    always_comb begin
        cmd           = '0;
        cmd.mode      = tkqs_pkg::MODE_RANK;
        cmd.count     = r_count;
        cmd.pick_rank = r_emit_rank;
        cmd.append    = r_append;
        unique case (r_state)
            ST_MSCAN: begin
                cmd.mode  = tkqs_pkg::MODE_MIN;
                cmd.load  = (r_step == '0);
                cmd.shift = (r_step != '0);
            end
            ST_WSCAN: begin
                cmd.mode  = tkqs_pkg::MODE_WORST;
                cmd.load  = (r_step == '0);
                cmd.shift = (r_step != '0);
            end
            ST_RSCAN: begin
                cmd.load  = (r_step == '0);
                cmd.shift = (r_step != '0);
            end
            ST_PUT: begin
                cmd.put   = 1'b1;
                cmd.aging = r_append || (|evict);
            end
            default: begin
            end
        endcase
    end

    // ring of cells, one per slot
    for (genvar g = 0; g < tkqs_pkg::MAX_KEEP; g++) begin : g_cell
        if (g == 0) begin : g_wrap
            assign ring_in[g] = ring_out[tkqs_pkg::MAX_KEEP-1];
        end else begin : g_link
            assign ring_in[g] = ring_out[g-1];
        end

        tkqs_cell u_cell (
            .i_clk     (i_clk),
            .i_cmd     (cmd),
            .i_start   (r_item.loop_start),
            .i_end     (r_item.loop_end),
            .i_quality (r_item.quality),
            .i_tol     (r_tol),
            .i_slot    (tkqs_pkg::t_slot'(g)),
            .i_ring    (ring_in[g]),
            .o_ring    (ring_out[g]),
            .o_evict   (evict[g]),
            .o_pick    (pick[g]),
            .o_entry   (entries[g])
        );
    end

    // select the entry holding the current rank
    always_comb begin
        pick_entry = '0;
        for (int i = 0; i < tkqs_pkg::MAX_KEEP; i++) begin
            if (pick[i]) begin
                pick_entry = tkqs_pkg::t_out_item'(pick_entry | entries[i]);
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep <= tkqs_pkg::KEEP_RESET;
            r_tol  <= tkqs_pkg::TOL_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                tkqs_pkg::REG_KEEP_COUNT:     r_keep <= i_cfg_data[tkqs_pkg::KEEP_W-1:0];
                tkqs_pkg::REG_NEAR_TOLERANCE: r_tol  <= i_cfg_data[tkqs_pkg::TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input item holding register
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_item;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_append    <= 1'b0;
            r_count     <= '0;
            r_step      <= '0;
            r_emit_rank <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_append <= (r_count < eff_keep(r_keep));
                        r_step   <= '0;
                        r_state  <= (r_count < eff_keep(r_keep)) ? ST_PUT : ST_MSCAN;
                    end
                end
                ST_MSCAN: begin
                    r_step <= scan_done ? '0 : r_step + 1'b1;
                    if (scan_done) begin
                        r_state <= ST_WSCAN;
                    end
                end
                ST_WSCAN: begin
                    r_step <= scan_done ? '0 : r_step + 1'b1;
                    if (scan_done) begin
                        r_state <= ST_PUT;
                    end
                end
                ST_PUT: begin
                    if (r_append) begin
                        r_count <= r_count + 1'b1;
                    end
                    r_step  <= '0;
                    r_state <= r_item.set_last ? ST_RSCAN : ST_IDLE;
                end
                ST_RSCAN: begin
                    r_step      <= scan_done ? '0 : r_step + 1'b1;
                    r_emit_rank <= '0;
                    if (scan_done) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        r_emit_rank <= r_emit_rank + 1'b1;
                        if (emit_final) begin
                            r_count <= '0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_go) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // next result: the picked entry, marked when it closes the set
    always_comb begin
        n_out              = pick_entry;
        n_out.final_result = emit_final;
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== sv/tkqs_checker.sv =====
module tkqs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input tkqs_pkg::t_out_item o_out_item
);

    // input ready drops once an item has been taken
    a_ready_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready stayed high after an item was taken");

    // no new item is taken while a set is still being emitted
    a_no_input_mid_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.final_result) |-> !o_in_ready)
        else $error("input taken while a set was still being emitted");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("output item changed while stalled");

    // reset empties the output register
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind top_k_quality_selector tkqs_checker u_tkqs_checker (.*);

// ===== test/tb_top_k_quality_selector.sv =====
module tb_top_k_quality_selector;
    import tkqs_pkg::*;

    localparam int IDLE_MAX      = 14;
    localparam int SETTLE_CYCLES = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_ITEMS  = 370;
    localparam int TAIL_ITEMS    = 30;
    localparam int AGE_CAP       = 65535;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_item             out_item;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // shadow of the kept entries and of the registers
    logic [POS_W-1:0]         kept_start_mem [MAX_KEEP];
    logic [POS_W-1:0]         kept_end_mem   [MAX_KEEP];
    logic signed [QUAL_W-1:0] kept_qual_mem  [MAX_KEEP];
    int unsigned              kept_age_mem   [MAX_KEEP];
    int                       kept_count = 0;
    logic [KEEP_W-1:0]        keep_cfg   = KEEP_RESET;
    logic [TOL_W-1:0]         tol_cfg    = TOL_RESET;

    t_in_item  cand_queue [$];
    t_out_item kept_due   [$];
    int        mismatch_cnt = 0;
    int        cand_total   = 0;
    int        in_gap       = 0;
    int        out_gap      = 0;
    bit        in_gaps_on   = 1'b0;
    bit        out_gaps_on  = 1'b0;
    bit        hold_req     = 1'b0;
    bit        hold_done    = 1'b0;
    int        hold_cnt     = 0;

    top_k_quality_selector i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // interval length, wrapping
    function automatic logic [POS_W-1:0] span_of_slot(int i);
        return kept_end_mem[i] - kept_start_mem[i];
    endfunction

    // shortest entry among those near the lowest quality, oldest on a tie
    function automatic int worst_slot();
        int  qmin;
        int  d;
        int  w;
        bit  have;
        qmin = kept_qual_mem[0];
        w    = 0;
        have = 1'b0;
        for (int i = 1; i < kept_count; i++) begin
            if (kept_qual_mem[i] < qmin) qmin = kept_qual_mem[i];
        end
        for (int i = 0; i < kept_count; i++) begin
            d = int'(kept_qual_mem[i]) - qmin;
            if (!(d < int'(tol_cfg) || d == 0)) continue;
            if (!have) begin
                w    = i;
                have = 1'b1;
            end else if (span_of_slot(i) < span_of_slot(w)) begin
                w = i;
            end else if (span_of_slot(i) == span_of_slot(w) &&
                         kept_age_mem[i] > kept_age_mem[w]) begin
                w = i;
            end
        end
        return w;
    endfunction

    // emission order: quality, then length, then age, then slot
    function automatic bit ranks_ahead(int a, int b);
        if (kept_qual_mem[a] != kept_qual_mem[b]) return kept_qual_mem[a] > kept_qual_mem[b];
        if (span_of_slot(a) != span_of_slot(b)) return span_of_slot(a) > span_of_slot(b);
        if (kept_age_mem[a] != kept_age_mem[b]) return kept_age_mem[a] > kept_age_mem[b];
        return a < b;
    endfunction

    task automatic store_entry(int slot, t_in_item c);
        for (int i = 0; i < kept_count; i++) begin
            if (kept_age_mem[i] < AGE_CAP) kept_age_mem[i]++;
        end
        kept_start_mem[slot] = c.loop_start;
        kept_end_mem[slot]   = c.loop_end;
        kept_qual_mem[slot]  = $signed(c.quality);
        kept_age_mem[slot]   = 0;
    endtask

    // take one candidate into the shadow store, queue the set on the last one
    task automatic apply_candidate(t_in_item c);
        int        k;
        int        w;
        int        n;
        int        best;
        bit        have;
        bit        taken [MAX_KEEP];
        t_out_item r;
        k = keep_cfg;
        if (k == 0) k = 1;
        if (k > MAX_KEEP) k = MAX_KEEP;
        if (kept_count < k) begin
            kept_count++;
            store_entry(kept_count - 1, c);
        end else if (kept_count > 0) begin
            w = worst_slot();
            if ($signed(c.quality) > kept_qual_mem[w]) store_entry(w, c);
        end
        if (!c.set_last) return;
        n = kept_count;
        for (int i = 0; i < MAX_KEEP; i++) taken[i] = 1'b0;
        for (int j = 0; j < n; j++) begin
            best = 0;
            have = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (!taken[i] && (!have || ranks_ahead(i, best))) begin
                    best = i;
                    have = 1'b1;
                end
            end
            taken[best]    = 1'b1;
            r.kept_start   = kept_start_mem[best];
            r.kept_end     = kept_end_mem[best];
            r.kept_quality = kept_qual_mem[best];
            r.final_result = (j == n - 1);
            kept_due.insert(kept_due.size(), r);
        end
        kept_count = 0;
    endtask

    // candidate driver
    always @(posedge clk) begin : drive_cands
        bit slot_free;
        if (!rst_n) begin
            in_valid <= 1'b0;
            in_gap   <= 0;
        end else begin
            slot_free = !in_valid || in_ready;
            if (in_valid && in_ready) apply_candidate(in_item);
            if (slot_free) begin
                if (in_gap > 0) begin
                    in_gap   <= in_gap - 1;
                    in_valid <= 1'b0;
                end else if (cand_queue.size() > 0) begin
                    in_item  <= cand_queue.pop_front();
                    in_valid <= 1'b1;
                    in_gap   <= in_gaps_on ? $urandom_range(0, IDLE_MAX) : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and output stalls
    always @(posedge clk) begin : take_results
        t_out_item due;
        int        g;
        if (!rst_n) begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end else begin
            if (out_valid && out_ready) begin
                if (kept_due.size() == 0) begin
                    $error("result with none expected: kept_start %h", out_item.kept_start);
                    mismatch_cnt++;
                end else begin
                    due = kept_due.pop_front();
                    if (out_item.kept_start !== due.kept_start) begin
                        $error("kept_start expected %h actual %h",
                               due.kept_start, out_item.kept_start);
                        mismatch_cnt++;
                    end
                    if (out_item.kept_end !== due.kept_end) begin
                        $error("kept_end expected %h actual %h",
                               due.kept_end, out_item.kept_end);
                        mismatch_cnt++;
                    end
                    if (out_item.kept_quality !== due.kept_quality) begin
                        $error("kept_quality expected %0d actual %0d",
                               $signed(due.kept_quality), $signed(out_item.kept_quality));
                        mismatch_cnt++;
                    end
                    if (out_item.final_result !== due.final_result) begin
                        $error("final_result expected %b actual %b",
                               due.final_result, out_item.final_result);
                        mismatch_cnt++;
                    end
                end
            end
            if (hold_req && !hold_done) begin
                out_ready <= 1'b0;
            end else if (out_valid && out_ready) begin
                g = out_gaps_on ? $urandom_range(0, IDLE_MAX) : 0;
                out_gap   <= g;
                out_ready <= (g == 0);
            end else if (out_gap > 0) begin
                out_gap   <= out_gap - 1;
                out_ready <= (out_gap == 1);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // long output hold-off, counted here
    always @(posedge clk) begin : hold_off
        if (hold_req && !hold_done) begin
            if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end
    end

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_KEEP_COUNT) keep_cfg = val[KEEP_W-1:0];
        else tol_cfg = val[TOL_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_cand(logic [POS_W-1:0] s, logic [POS_W-1:0] e, int q, bit last);
        t_in_item c;
        c.loop_start = s;
        c.loop_end   = e;
        c.quality    = q[QUAL_W-1:0];
        c.set_last   = last;
        cand_queue.insert(cand_queue.size(), c);
        cand_total++;
    endtask

    // wait for the block to drain, then let any trailing work settle
    task automatic wait_drained();
        while (cand_queue.size() > 0 || in_valid || kept_due.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random candidate, quality mostly clustered around the set's base
    function automatic t_in_item make_cand(int q_base, bit last);
        int          q;
        int unsigned len;
        t_in_item    c;
        case ($urandom_range(0, 9))
            0, 1:    q = int'($urandom_range(0, 65535)) - 32768;
            2:       q = q_base;
            default: q = q_base + int'($urandom_range(0, 1200)) - 600;
        endcase
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        case ($urandom_range(0, 7))
            0:       len = $urandom;
            1, 2:    len = $urandom_range(0, 15);
            default: len = $urandom_range(0, 4000);
        endcase
        c.loop_start = $urandom;
        c.loop_end   = c.loop_start + len;
        c.quality    = q[QUAL_W-1:0];
        c.set_last   = last;
        return c;
    endfunction

    // a run of sets; the final one may be left open across a register change
    task automatic run_sets(int n_sets, bit leave_open);
        int size;
        int q_base;
        @(negedge clk);
        in_gaps_on  = ($urandom_range(0, 2) != 0);
        out_gaps_on = ($urandom_range(0, 2) != 0);
        for (int s = 0; s < n_sets; s++) begin
            size   = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 12);
            q_base = int'($urandom_range(0, 65535)) - 32768;
            for (int i = 0; i < size; i++) begin
                cand_queue.insert(cand_queue.size(), make_cand(q_base,
                    (i == size - 1) && !(leave_open && s == n_sets - 1)));
                cand_total++;
            end
        end
        wait_drained();
    endtask

    initial begin
        int step;
        int keep_val;
        int tol_val;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, tolerance window, ties, inverted intervals
        cfg_write(REG_KEEP_COUNT, 3);
        @(negedge clk);
        queue_cand(32'h0000_0000, 32'hFFFF_FFFF, 32767, 1'b1);
        queue_cand(100, 200, 1000, 1'b0);
        queue_cand(300, 350, 1200, 1'b0);
        queue_cand(10, 20, 1100, 1'b0);
        queue_cand(0, 1000, 1000, 1'b0);
        queue_cand(0, 1000, 2000, 1'b0);
        queue_cand(32'hFFFF_FFFF, 4, 1600, 1'b0);
        queue_cand(7, 7, -32768, 1'b0);
        queue_cand(50, 150, 1000, 1'b0);
        queue_cand(5, 105, 32767, 1'b1);
        queue_cand(0, 10, 500, 1'b0);
        queue_cand(20, 30, 500, 1'b0);
        queue_cand(40, 50, 500, 1'b0);
        queue_cand(60, 70, 501, 1'b0);
        queue_cand(80, 90, -1, 1'b1);
        queue_cand(32'h0000_0000, 32'h0000_0000, -32768, 1'b0);
        queue_cand(32'hFFFF_FFFF, 32'hFFFF_FFFF, -32768, 1'b0);
        queue_cand(32'h0000_0000, 32'hFFFF_FFFF, 0, 1'b1);
        wait_drained();

        // output held off for a long stretch while sets keep coming
        cfg_write(REG_KEEP_COUNT, 4);
        @(negedge clk);
        hold_req = 1'b1;
        run_sets(6, 1'b0);

        // register sweep, extremes first
        step = 0;
        while (cand_total < RANDOM_ITEMS - TAIL_ITEMS) begin
            case (step)
                0:       begin keep_val = 16; tol_val = 492;   end
                1:       begin keep_val = 1;  tol_val = 0;     end
                2:       begin keep_val = 0;  tol_val = 32767; end
                3:       begin keep_val = 31; tol_val = 1;     end
                4:       begin keep_val = 2;  tol_val = 0;     end
                5:       begin keep_val = 16; tol_val = 32767; end
                6:       begin keep_val = 5;  tol_val = 492;   end
                7:       begin keep_val = 8;  tol_val = 20;    end
                default: begin
                    keep_val = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31)
                                                           : $urandom_range(1, 16);
                    tol_val  = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 32767)
                                                           : $urandom_range(0, 1500);
                end
            endcase
            cfg_write(REG_KEEP_COUNT, keep_val[CFG_DATA_W-1:0]);
            cfg_write(REG_NEAR_TOLERANCE, tol_val[CFG_DATA_W-1:0]);
            run_sets($urandom_range(2, 5), (step % 3) == 2);
            step++;
        end
        run_sets(1, 1'b0);

        if (mismatch_cnt == 0 && kept_due.size() == 0) begin
            $display("[top_k_quality_selector] OK");
        end else begin
            $display("[top_k_quality_selector] ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4000000;
        $display("[top_k_quality_selector] ERROR");
        $finish;
    end

endmodule

// ===== top_k_quality_selector.f =====
sv/tkqs_pkg.sv
sv/tkqs_cell.sv
sv/top_k_quality_selector.sv
sv/tkqs_checker.sv
test/tb_top_k_quality_selector.sv
